FILE: rtl/bmhq_pkg.sv
// -----------------------------------------------------------------------------
// bmhq_pkg
// shared types and constants of the binary min-heap priority queue
// -----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;

   localparam int REQ_W = 48;   // 44 bits of fields, padded to whole bytes
   localparam int RSP_W = 80;   // 78 bits of fields, padded to whole bytes

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_EXTRACT  = 2'd1,
      CMD_DECREASE = 2'd2,
      CMD_DELETE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTDEC   = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SET_OVF,
      OP_SET_EMPTY,
      OP_SET_BADPOS,
      OP_SET_NOTDEC,
      OP_INS,
      OP_RD_POS,
      OP_RD_ROOT,
      OP_CAP_REM,
      OP_SET_IDX_POS,
      OP_DEL_CAP,
      OP_TAIL_RD,
      OP_TAIL_GET,
      OP_UP_RD,
      OP_UP_MOVE,
      OP_PUT_KEY,
      OP_DN_RDL,
      OP_DN_RDR,
      OP_DN_STEP,
      OP_RSP
   } dp_op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    pos_bad;
      logic    not_dec;
      logic    idx_zero;
      logic    up_swap;
      logic    dn_leaf;
      logic    dn_stop;
      logic    cnt_zero;
      logic    rsp_busy;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_EXT_CAP,
      S_TAIL_RD,
      S_TAIL_GET,
      S_DEC_CHK,
      S_DEL_CAP,
      S_DEL_UP,
      S_DEL_MV,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_FIN,
      S_RESP
   } ctl_state_type;

endpackage

`default_nettype wire

FILE: rtl/bmhq_ctrl.sv
// -----------------------------------------------------------------------------
// bmhq_ctrl
// command sequencer: walks each command through its heap steps
// -----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output dp_op_type        op
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            case (stat.cmd)
               CMD_INSERT:   state_in = stat.full    ? S_FIN : S_UP_RD;
               CMD_EXTRACT:  state_in = stat.empty   ? S_FIN : S_EXT_CAP;
               CMD_DECREASE: state_in = stat.pos_bad ? S_FIN : S_DEC_CHK;
               default:      state_in = stat.pos_bad ? S_FIN : S_DEL_CAP;
            endcase
         end
         S_EXT_CAP:  state_in = S_TAIL_GET;
         S_TAIL_RD:  state_in = S_TAIL_GET;
         S_TAIL_GET: state_in = stat.cnt_zero ? S_FIN : S_DN_RDL;
         S_DEC_CHK:  state_in = stat.not_dec ? S_FIN : S_UP_RD;
         S_DEL_CAP:  state_in = S_DEL_UP;
         S_DEL_UP:   state_in = stat.idx_zero ? S_TAIL_RD : S_DEL_MV;
         S_DEL_MV:   state_in = S_DEL_UP;
         S_UP_RD:    state_in = stat.idx_zero ? S_FIN : S_UP_CMP;
         S_UP_CMP:   state_in = stat.up_swap ? S_UP_RD : S_FIN;
         S_DN_RDL:   state_in = stat.dn_leaf ? S_FIN : S_DN_RDR;
         S_DN_RDR:   state_in = S_DN_CMP;
         S_DN_CMP:   state_in = stat.dn_stop ? S_FIN : S_DN_RDL;
         S_FIN:      state_in = S_RESP;
         S_RESP:     if (!stat.rsp_busy) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath command
   always_comb begin
      op = OP_IDLE;
      case (state_ff)
         S_IDLE:     if (req_tvalid) op = OP_LOAD;
         S_DECODE: begin
            case (stat.cmd)
               CMD_INSERT:   op = stat.full    ? OP_SET_OVF    : OP_INS;
               CMD_EXTRACT:  op = stat.empty   ? OP_SET_EMPTY  : OP_RD_ROOT;
               CMD_DECREASE: op = stat.pos_bad ? OP_SET_BADPOS : OP_RD_POS;
               default:      op = stat.pos_bad ? OP_SET_BADPOS : OP_RD_POS;
            endcase
         end
         S_EXT_CAP:  op = OP_CAP_REM;
         S_TAIL_RD:  op = OP_TAIL_RD;
         S_TAIL_GET: op = stat.cnt_zero ? OP_IDLE : OP_TAIL_GET;
         S_DEC_CHK:  op = stat.not_dec ? OP_SET_NOTDEC : OP_SET_IDX_POS;
         S_DEL_CAP:  op = OP_DEL_CAP;
         S_DEL_UP:   op = stat.idx_zero ? OP_IDLE : OP_UP_RD;
         S_DEL_MV:   op = OP_UP_MOVE;
         S_UP_RD:    op = stat.idx_zero ? OP_PUT_KEY : OP_UP_RD;
         S_UP_CMP:   op = stat.up_swap ? OP_UP_MOVE : OP_PUT_KEY;
         S_DN_RDL:   op = stat.dn_leaf ? OP_PUT_KEY : OP_DN_RDL;
         S_DN_RDR:   op = OP_DN_RDR;
         S_DN_CMP:   op = stat.dn_stop ? OP_PUT_KEY : OP_DN_STEP;
         S_FIN:      op = OP_RD_ROOT;
         S_RESP:     op = stat.rsp_busy ? OP_IDLE : OP_RSP;
         default:    op = OP_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/bmhq_dpath.sv
// -----------------------------------------------------------------------------
// bmhq_dpath
// heap memory, working registers, limit register and result register
// -----------------------------------------------------------------------------
`default_nettype none

module bmhq_dpath
   import bmhq_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [REQ_W-1:0]   req_tdata,
   input  wire logic               csr_valid,
   input  wire logic [10:0]        csr_wdata,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [RSP_W-1:0]        rsp_tdata,
   input  wire dp_op_type          op,
   output dp_stat_type             stat
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > 11) ? CW : 11;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

   logic [31:0]   heap_mem_ff [MAX_ENTRIES];
   logic [31:0]   rd_data_ff;
   cmd_type       cmd_ff, cmd_in;
   logic [31:0]   key_ff, key_in;
   logic [9:0]    pos_ff, pos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   rem_ff, rem_in;
   status_type    st_ff, st_in;
   logic [31:0]   lval_ff, lval_in;
   logic [10:0]   cap_ff;
   logic          rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;

   logic [IW-1:0] parent;
   logic [IW+1:0] lchild, rchild, cnt_w;
   logic [XW-1:0] cap_eff, cnt_x;
   logic          l_lt, r_ok, r_lt, r_pick;
   logic [31:0]   best;

   assign parent = (idx_ff - IW'(1)) >> 1;
   assign lchild = {1'b0, idx_ff, 1'b1};
   assign rchild = lchild + (IW+2)'(1);
   assign cnt_w  = (IW+2)'(cnt_ff);
   assign cnt_x  = XW'(cnt_ff);

   always_comb begin
      cap_eff = XW'(cap_ff);
      if (cap_ff == 11'd0)   cap_eff = XW'(1);
      if (cap_eff > MAX_X)   cap_eff = MAX_X;
   end

   // down-step choice: left beats the held key, right must beat the better of the two
   assign l_lt   = $signed(lval_ff) < $signed(key_ff);
   assign best   = l_lt ? lval_ff : key_ff;
   assign r_ok   = rchild < cnt_w;
   assign r_lt   = $signed(rd_data_ff) < $signed(best);
   assign r_pick = r_ok && r_lt;

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.full     = cnt_x >= cap_eff;
      stat.empty    = (cnt_ff == '0);
      stat.pos_bad  = XW'(pos_ff) >= cnt_x;
      stat.not_dec  = $signed(rd_data_ff) < $signed(key_ff);
      stat.idx_zero = (idx_ff == '0);
      stat.up_swap  = $signed(key_ff) < $signed(rd_data_ff);
      stat.dn_leaf  = lchild >= cnt_w;
      stat.dn_stop  = !l_lt && !r_pick;
      stat.cnt_zero = (cnt_ff == '0);
      stat.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      cmd_in  = cmd_ff;
      key_in  = key_ff;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      st_in   = st_ff;
      lval_in = lval_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = key_ff;
      case (op)
         OP_LOAD: begin
            cmd_in = cmd_type'(req_tdata[1:0]);
            key_in = req_tdata[33:2];
            pos_in = req_tdata[43:34];
            rem_in = INT_MAX;
            st_in  = ST_OK;
         end
         OP_SET_OVF:    st_in = ST_OVERFLOW;
         OP_SET_EMPTY:  st_in = ST_EMPTY;
         OP_SET_BADPOS: st_in = ST_BADPOS;
         OP_SET_NOTDEC: st_in = ST_NOTDEC;
         OP_INS: begin
            idx_in = IW'(cnt_ff);
            cnt_in = cnt_ff + CW'(1);
         end
         OP_RD_POS: begin
            rd_en   = 1'b1;
            rd_addr = IW'(pos_ff);
         end
         OP_RD_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         OP_CAP_REM: begin
            rem_in  = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = IW'(cnt_ff - CW'(1));
            cnt_in  = cnt_ff - CW'(1);
         end
         OP_SET_IDX_POS: idx_in = IW'(pos_ff);
         OP_DEL_CAP: begin
            rem_in = rd_data_ff;
            idx_in = IW'(pos_ff);
         end
         OP_TAIL_RD: begin
            rd_en   = 1'b1;
            rd_addr = IW'(cnt_ff - CW'(1));
            cnt_in  = cnt_ff - CW'(1);
         end
         OP_TAIL_GET: begin
            key_in = rd_data_ff;
            idx_in = '0;
         end
         OP_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = parent;
         end
         OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = parent;
         end
         OP_PUT_KEY:    wr_en = 1'b1;
         OP_DN_RDL: begin
            rd_en   = 1'b1;
            rd_addr = IW'(lchild);
         end
         OP_DN_RDR: begin
            lval_in = rd_data_ff;
            rd_en   = r_ok;
            rd_addr = IW'(rchild);
         end
         OP_DN_STEP: begin
            wr_en   = 1'b1;
            wr_data = r_pick ? rd_data_ff : lval_ff;
            idx_in  = r_pick ? IW'(rchild) : IW'(lchild);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= heap_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      st_ff   <= st_in;
      lval_ff <= lval_in;
      if (op == OP_RSP) begin
         rsp_data_ff <= {2'b00, st_ff, 11'(cnt_ff), (cnt_ff == '0) ? INT_MAX : rd_data_ff,
                         rem_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cap_ff       <= 11'd1024;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_valid) cap_ff <= csr_wdata;
         if (op == OP_RSP)       rsp_valid_ff <= 1'b1;
         else if (rsp_tready)    rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/binary_min_heap_queue_top.sv
// -----------------------------------------------------------------------------
// binary_min_heap_queue_top
// priority queue of signed 32-bit keys held as an array-stored binary min-heap
// -----------------------------------------------------------------------------
// usage
//   req_ carries one command per beat: insert, extract minimum, decrease key
//   at a position, delete at a position. rsp_ returns exactly one beat per
//   command with the removed key, the root key after the command, the count
//   and a status code. csr_ writes the capacity limit (0 acts as 1, values
//   above MAX_ENTRIES act as MAX_ENTRIES); write it only while idle.
// sequencing
//   one command at a time, next one taken after the result is loaded. the
//   heap memory has one read and one write port with registered read data:
//   sift up works each level as read parent, then compare and move; sift
//   down as read left, read right, then compare and move. an insert sifts
//   up; an extract sifts down; a delete carries its slot to the root, then
//   sifts down.
// reset
//   count goes to zero and the limit to 1024; memory contents are not cleared
//   since only entries below the count are ever used.
// stall
//   the result sits in an output register; if rsp_tready is low the next
//   command is still taken and worked on, and waits only at its own result.
// -----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // command beat
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // command[1:0], key_value[33:2], position[43:34]
   // result beat
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // removed_value[31:0], current_min[63:32],
                                               // item_count[74:64], status[77:75]
   // capacity limit write
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [10:0]       csr_wdata
);

   dp_op_type   op;
   dp_stat_type stat;

   // limit register always takes the write
   assign csr_ready = 1'b1;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   bmhq_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .op         (op),
      .stat       (stat)
   );

endmodule

`default_nettype wire

FILE: rtl/bmhq_checker.sv
// -----------------------------------------------------------------------------
// bmhq_checker
// port-level checks of the heap queue, bound to the top level
// -----------------------------------------------------------------------------
`default_nettype none

module bmhq_props
   import bmhq_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic [RSP_W-1:0]  rsp_tdata
);

   // result valid cleared by reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one command at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("command taken while busy");

   // empty status only with no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[77:75] == ST_EMPTY) |-> (rsp_tdata[74:64] == 11'd0))
      else $error("empty status with entries held");

   // empty heap shows the largest key as minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[74:64] == 11'd0) |-> (rsp_tdata[63:32] == INT_MAX))
      else $error("minimum of empty heap wrong");

endmodule

bind binary_min_heap_queue_top bmhq_props u_bmhq_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
